FILE: sv/vtpd_pkg.sv
`default_nettype none
package vtpd_pkg;
  localparam int unsigned VtxWidth = 16;
  localparam int unsigned ResWidth = 32;
  localparam int unsigned RowWidth = 64;
  localparam int unsigned NumRows  = 4;
  localparam int unsigned IdxWidth = 2;
  localparam int unsigned OutFrac  = 16;
  localparam int unsigned InFrac   = 8;
  localparam int unsigned NumWidth = ResWidth + OutFrac;
  localparam int unsigned QDepth   = 2;

  localparam logic [IdxWidth-1:0] RegRowZero  = 2'd0;
  localparam logic [IdxWidth-1:0] RegRowOne   = 2'd1;
  localparam logic [IdxWidth-1:0] RegRowTwo   = 2'd2;
  localparam logic [IdxWidth-1:0] RegRowThree = 2'd3;

  typedef logic signed [ResWidth-1:0] res_t;

  typedef struct packed {
    res_t x;
    res_t y;
    res_t z;
    res_t w;
    logic wzero;
    logic sat;
  } dot_word_t;

  typedef struct packed {
    res_t x;
    res_t y;
    res_t z;
    res_t w;
    logic wzero;
    logic sat;
  } out_word_t;

  function automatic res_t clamp_s(input logic signed [63:0] v, output logic sat);
    sat = 1'b0;
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[ResWidth-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: sv/vtpd_front.sv
`default_nettype none
module vtpd_front #(
  parameter int unsigned COEF_WIDTH = 16,
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire  [1:0]                 cfg_idx_i,
  input  wire  [63:0]                cfg_data_i,
  input  wire                        valid_i,
  input  wire                        stall_i,
  input  wire  signed [15:0]         x_i,
  input  wire  signed [15:0]         y_i,
  input  wire  signed [15:0]         z_i,
  input  wire  signed [15:0]         w_i,
  output logic                       valid_o,
  output vtpd_pkg::dot_word_t        word_o
);
  import vtpd_pkg::*;

  localparam int unsigned ProdWidth = COEF_WIDTH + VtxWidth;
  localparam int unsigned SumWidth  = ProdWidth + 2;
  localparam int Up = int'(OutFrac) - int'(InFrac + FRAC_BITS);

  logic [RowWidth-1:0] row_q [NumRows];
  logic signed [ProdWidth-1:0] prod_q [NumRows][4];
  logic v1_q, v2_q;
  dot_word_t word_d, word_q;
  logic signed [VtxWidth-1:0] vtx [4];

  assign vtx[0] = x_i;
  assign vtx[1] = y_i;
  assign vtx[2] = z_i;
  assign vtx[3] = w_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= 64'h0000000000000100;
      row_q[1] <= 64'h0000000001000000;
      row_q[2] <= 64'h0000010000000000;
      row_q[3] <= 64'h0100000000000000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRowZero:  row_q[0] <= cfg_data_i;
        RegRowOne:   row_q[1] <= cfg_data_i;
        RegRowTwo:   row_q[2] <= cfg_data_i;
        RegRowThree: row_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      for (int r = 0; r < NumRows; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_q[r][c] <= ProdWidth'($signed(row_q[r][16*c +: COEF_WIDTH]) * vtx[c]);
        end
      end
      word_q <= word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (!stall_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_comb begin
    logic signed [SumWidth-1:0] acc;
    logic signed [63:0] al;
    logic s;
    res_t r [NumRows];
    word_d = '0;
    for (int i = 0; i < NumRows; i++) begin
      acc = SumWidth'(prod_q[i][0]) + SumWidth'(prod_q[i][1])
          + SumWidth'(prod_q[i][2]) + SumWidth'(prod_q[i][3]);
      if (Up >= 0) al = 64'(acc) <<< Up;
      else         al = 64'(acc) >>> (-Up);
      r[i] = clamp_s(al, s);
      word_d.sat = word_d.sat | s;
    end
    word_d.x = r[0];
    word_d.y = r[1];
    word_d.z = r[2];
    word_d.w = r[3];
    word_d.wzero = (r[3] == '0);
  end

  assign valid_o = v2_q;
  assign word_o  = word_q;

`ifndef SYNTHESIS
  ap_wz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (word_o.wzero == (word_o.w == '0)))
    else $error("wzero flag mismatch");
  ap_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!stall_i && v1_q) |=> v2_q)
    else $error("stage lost word");
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_i |=> $stable(v2_q))
    else $error("stage moved under stall");
`endif
endmodule
`default_nettype wire

FILE: sv/vtpd_queue.sv
`default_nettype none
module vtpd_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  vtpd_pkg::dot_word_t data_i,
  output logic                full_o,
  input  wire                 pop_i,
  output logic                empty_o,
  output logic [3:0]          cnt_o,
  output vtpd_pkg::dot_word_t data_o
);
  import vtpd_pkg::*;

  localparam int unsigned Depth = 8;
  dot_word_t mem_q [Depth];
  logic [2:0] wp_q, rp_q;
  logic [3:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= wp_q + 3'd1;
      if (pop_i && !empty_o) rp_q <= rp_q + 3'd1;
      cnt_q <= cnt_q + 4'(push_i && !full_o) - 4'(pop_i && !empty_o);
    end
  end

  assign full_o  = (cnt_q == 4'(Depth));
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;
  assign data_o  = mem_q[rp_q];

`ifndef SYNTHESIS
  ap_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 4'(Depth))
    else $error("queue count overflow");
  ap_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    3'(wp_q - rp_q) == cnt_q[2:0])
    else $error("queue pointer mismatch");
  ap_emp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o && !push_i) |=> empty_o)
    else $error("queue filled from nothing");
`endif
endmodule
`default_nettype wire

FILE: sv/vtpd_div.sv
`default_nettype none
module vtpd_div (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  input  vtpd_pkg::dot_word_t word_i,
  output logic                ready_o,
  output logic                valid_o,
  input  wire                 stall_i,
  output vtpd_pkg::out_word_t word_o
);
  import vtpd_pkg::*;

  localparam int unsigned Steps = NumWidth;
  localparam int unsigned Lat = Steps + 2;

  typedef struct packed {
    logic [NumWidth-1:0] rem;
    logic [NumWidth-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic [NumWidth-1:0] n;
    logic [NumWidth-1:0] r;
    logic [NumWidth-1:0] q;
    logic                neg;
  } slot_t;

  logic             vld_q [Lat];
  dot_word_t        info_q [Lat];
  slot_t            st_q [Lat][3];
  logic [ResWidth-1:0] dmag_q [Lat];
  logic             adv;

  assign adv = !(valid_o && stall_i);
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < Lat; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      info_q[0] <= word_i;
      dmag_q[0] <= word_i.w[ResWidth-1] ? ResWidth'(-word_i.w) : word_i.w;
      for (int k = 0; k < 3; k++) begin
        logic signed [ResWidth-1:0] v;
        v = (k == 0) ? word_i.x : (k == 1) ? word_i.y : word_i.z;
        st_q[0][k].n   <= {(v[ResWidth-1] ? ResWidth'(-v) : v), {OutFrac{1'b0}}};
        st_q[0][k].r   <= '0;
        st_q[0][k].q   <= '0;
        st_q[0][k].neg <= v[ResWidth-1] ^ word_i.w[ResWidth-1];
      end
      for (int i = 1; i <= Steps; i++) begin
        info_q[i] <= info_q[i-1];
        dmag_q[i] <= dmag_q[i-1];
        for (int k = 0; k < 3; k++) begin
          logic [NumWidth:0] t;
          t = {st_q[i-1][k].r, st_q[i-1][k].n[NumWidth-1]};
          st_q[i][k].neg <= st_q[i-1][k].neg;
          st_q[i][k].n   <= st_q[i-1][k].n << 1;
          if (t >= (NumWidth+1)'(dmag_q[i-1])) begin
            st_q[i][k].r <= NumWidth'(t - (NumWidth+1)'(dmag_q[i-1]));
            st_q[i][k].q <= {st_q[i-1][k].q[NumWidth-2:0], 1'b1};
          end else begin
            st_q[i][k].r <= t[NumWidth-1:0];
            st_q[i][k].q <= {st_q[i-1][k].q[NumWidth-2:0], 1'b0};
          end
        end
      end
      info_q[Lat-1] <= info_q[Lat-2];
      dmag_q[Lat-1] <= dmag_q[Lat-2];
      st_q[Lat-1] <= st_q[Lat-2];
    end
  end

  always_comb begin
    dot_word_t in;
    logic s;
    res_t q [3];
    in = info_q[Lat-1];
    s = in.sat;
    for (int k = 0; k < 3; k++) begin
      logic signed [63:0] sq;
      logic sk;
      sq = st_q[Lat-1][k].neg ? -$signed(64'(st_q[Lat-1][k].q))
                              : $signed(64'(st_q[Lat-1][k].q));
      q[k] = clamp_s(sq, sk);
      if (!in.wzero) s = s | sk;
    end
    word_o.x = in.wzero ? in.x : q[0];
    word_o.y = in.wzero ? in.y : q[1];
    word_o.z = in.wzero ? in.z : q[2];
    word_o.w = in.w;
    word_o.wzero = in.wzero;
    word_o.sat = s;
  end

  assign valid_o = vld_q[Lat-1];

`ifndef SYNTHESIS
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o)
    else $error("divider dropped stalled word");
  ap_wz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && word_o.wzero) |-> (word_o.w == '0))
    else $error("wzero with nonzero w");
  ap_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (word_o.w == info_q[Lat-1].w))
    else $error("w altered");
`endif
endmodule
`default_nettype wire

FILE: sv/vertex_transform_perspective_divide_core.sv
// Vertex transform with perspective divide.
// Input queue side: drive in_*_i and raise push; the vertex is taken on a
// clock edge where push is high and full is low.
// Result queue side: while empty is low the oldest result sits on out_*_o,
// w_was_zero_o and saturated_o; pop on an edge with empty low takes it.
// Configuration: cfg_we_i writes cfg_data_i into row cfg_idx_i (0..3) in the
// same edge; write only while the block is idle.
// Pipeline: a multiply register and a sum register in the front, then the
// middle queue, then the pipelined radix-2 divider (setup, 48 quotient-bit
// stages and an output stage).
// Throughput: one vertex per cycle while pop stays high, set by the fully
// pipelined divider.
// Reset clears every pipeline valid bit and the queue, and restores the
// identity matrix. When the receiver holds pop low the divider freezes, the
// middle queue and the front take up to seven more vertices, and full rises
// after that.
`default_nettype none
module vertex_transform_perspective_divide_core #(
  parameter int unsigned COEF_WIDTH = 16,
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [1:0]         cfg_idx_i,
  input  wire  [63:0]        cfg_data_i,
  input  wire                push,
  output logic               full,
  input  wire  signed [15:0] in_x_i,
  input  wire  signed [15:0] in_y_i,
  input  wire  signed [15:0] in_z_i,
  input  wire  signed [15:0] in_w_i,
  output logic               empty,
  input  wire                pop,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic signed [31:0] out_w_o,
  output logic               w_was_zero_o,
  output logic               saturated_o
);
  import vtpd_pkg::*;

  logic f_valid, q_full, q_empty, d_ready, d_valid, f_stall;
  dot_word_t f_word, q_word;
  out_word_t d_word;
  logic [1:0] infl_q;
  logic [3:0] q_cnt;

  // front can hold up to two words; keep room in the queue for them
  logic room;
  assign f_stall = 1'b0;
  assign full = q_full;

  vtpd_front #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .valid_i(push && !full), .stall_i(f_stall),
    .x_i(in_x_i), .y_i(in_y_i), .z_i(in_z_i), .w_i(in_w_i),
    .valid_o(f_valid), .word_o(f_word)
  );

  vtpd_queue u_queue (
    .clk_i, .rst_ni, .push_i(f_valid), .data_i(f_word), .full_o(room),
    .pop_i(d_ready), .empty_o(q_empty), .cnt_o(q_cnt), .data_o(q_word)
  );

  // reserve space for words still in the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) infl_q <= '0;
    else infl_q <= {infl_q[0], push && !full};
  end
  assign q_full = room || ((q_cnt + 4'(infl_q[0]) + 4'(infl_q[1])) >= 4'd7);

  vtpd_div u_div (
    .clk_i, .rst_ni, .valid_i(!q_empty), .word_i(q_word), .ready_o(d_ready),
    .valid_o(d_valid), .stall_i(!pop), .word_o(d_word)
  );

  assign empty = !d_valid;
  assign out_x_o = d_word.x;
  assign out_y_o = d_word.y;
  assign out_z_o = d_word.z;
  assign out_w_o = d_word.w;
  assign w_was_zero_o = d_word.wzero;
  assign saturated_o = d_word.sat;

`ifndef SYNTHESIS
  ap_nf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(f_valid && room))
    else $error("front word lost");
  ap_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped");
  ap_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> (infl_q[0]))
    else $error("inflight count slip");
`endif
endmodule
`default_nettype wire
